// ----- design/gbl_pkg.sv -----
// shared types and constants for the gap buffer line editor
`default_nettype none
package gbl_pkg;

    localparam int P_POS_W  = 7;
    localparam int P_CHAR_W = 8;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NODEL = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MOVE,
        S_SHIFT_L,
        S_SHIFT_R,
        S_APPLY,
        S_EMIT,
        S_RD_ADDR,
        S_RD_DATA
    } t_state;

endpackage
`default_nettype wire

// ----- design/gbl_text_ram.sv -----
// text store: one write port, one registered read port
`default_nettype none
module gbl_text_ram
    import gbl_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic [P_CHAR_W-1:0] i_wdata,
    input  wire logic                i_re,
    input  wire logic [AW-1:0]       i_raddr,
    output logic      [P_CHAR_W-1:0] o_rdata
);

    logic [P_CHAR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- design/gbl_ctrl.sv -----
// request sequencer: gap moves, edits, read out and result register
`default_nettype none
module gbl_ctrl
    import gbl_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int LW = $clog2(CAPACITY + 1),
    localparam int AW = $clog2(CAPACITY)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_req_type,
    input  wire logic [P_POS_W-1:0]  i_position,
    input  wire logic [P_CHAR_W-1:0] i_char_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [P_CHAR_W-1:0]      o_char_out,
    output logic                     o_char_valid,
    output logic                     o_last,
    output logic [1:0]               o_status,
    output logic [P_POS_W-1:0]       o_length_now,
    output logic                     o_was_modified,
    output logic                     o_mem_we,
    output logic [AW-1:0]            o_mem_waddr,
    output logic [P_CHAR_W-1:0]      o_mem_wdata,
    output logic                     o_mem_re,
    output logic [AW-1:0]            o_mem_raddr,
    input  wire logic [P_CHAR_W-1:0] i_mem_rdata
);

    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [P_POS_W-1:0]  r_pos, n_pos;
    logic [P_CHAR_W-1:0] r_ch, n_ch;
    t_status             r_st, n_st;
    logic [LW-1:0]       r_gs, n_gs;
    logic [LW-1:0]       r_ge, n_ge;
    logic [LW-1:0]       r_len, n_len;
    logic                r_mod, n_mod;
    logic [LW-1:0]       r_idx, n_idx;

    logic                r_ov, n_ov;
    logic [P_CHAR_W-1:0] r_oc, n_oc;
    logic                r_ocv, n_ocv;
    logic                r_olast, n_olast;
    t_status             r_ost, n_ost;
    logic [LW-1:0]       r_olen, n_olen;
    logic                r_omod, n_omod;

    logic [P_POS_W-1:0]  len_w;
    logic [LW-1:0]       pos_l;
    logic [LW-1:0]       phys;
    logic                out_free;
    logic                rd_last;

    assign len_w    = P_POS_W'(r_len);
    assign pos_l    = LW'(r_pos);
    assign phys     = (r_idx < r_gs) ? r_idx : LW'(r_idx + (r_ge - r_gs));
    assign out_free = !r_ov || i_out_ready;
    assign rd_last  = (LW'(r_idx + 1'b1) == r_len);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                case (r_req)
                    REQ_INSERT: begin
                        if (r_pos > len_w || r_len >= CAP_L) n_state = S_EMIT;
                        else n_state = S_MOVE;
                    end
                    REQ_DELETE: begin
                        if (r_len == '0 || r_pos >= len_w) n_state = S_EMIT;
                        else n_state = S_MOVE;
                    end
                    REQ_READ: begin
                        if (r_len == '0) n_state = S_EMIT;
                        else n_state = S_RD_ADDR;
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_MOVE: begin
                if (r_gs > pos_l) n_state = S_SHIFT_L;
                else if (r_gs < pos_l) n_state = S_SHIFT_R;
                else n_state = S_APPLY;
            end
            S_SHIFT_L: n_state = S_MOVE;
            S_SHIFT_R: n_state = S_MOVE;
            S_APPLY:   n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            S_RD_ADDR: n_state = S_RD_DATA;
            S_RD_DATA: begin
                if (out_free) n_state = rd_last ? S_IDLE : S_RD_ADDR;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory strobes
    always_comb begin
        n_req   = r_req;
        n_pos   = r_pos;
        n_ch    = r_ch;
        n_st    = r_st;
        n_gs    = r_gs;
        n_ge    = r_ge;
        n_len   = r_len;
        n_mod   = r_mod;
        n_idx   = r_idx;
        n_ov    = r_ov && !i_out_ready;
        n_oc    = r_oc;
        n_ocv   = r_ocv;
        n_olast = r_olast;
        n_ost   = r_ost;
        n_olen  = r_olen;
        n_omod  = r_omod;
        o_in_ready  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(r_gs);
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = AW'(r_ge);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_req = t_req'(i_req_type);
                n_pos = i_position;
                n_ch  = i_char_in;
            end
            S_CHECK: begin
                n_st  = ST_OK;
                n_idx = '0;
                case (r_req)
                    REQ_INSERT: begin
                        if (r_pos > len_w) n_st = ST_RANGE;
                        else if (r_len >= CAP_L) n_st = ST_FULL;
                    end
                    REQ_DELETE: begin
                        if (r_len == '0) n_st = ST_NODEL;
                        else if (r_pos > len_w) n_st = ST_RANGE;
                        else if (r_pos == len_w) n_st = ST_NODEL;
                    end
                    REQ_READ: begin
                    end
                    default: begin
                        if (r_len != '0) n_mod = 1'b1;
                        n_gs  = '0;
                        n_ge  = CAP_L;
                        n_len = '0;
                    end
                endcase
            end
            S_MOVE: begin
                if (r_gs > pos_l) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(r_gs - 1'b1);
                end else if (r_gs < pos_l) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(r_ge);
                end
            end
            S_SHIFT_L: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_ge - 1'b1);
                n_gs = r_gs - 1'b1;
                n_ge = r_ge - 1'b1;
            end
            S_SHIFT_R: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_gs);
                n_gs = r_gs + 1'b1;
                n_ge = r_ge + 1'b1;
            end
            S_APPLY: begin
                n_mod = 1'b1;
                if (r_req == REQ_INSERT) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = AW'(r_gs);
                    o_mem_wdata = r_ch;
                    n_gs  = r_gs + 1'b1;
                    n_len = r_len + 1'b1;
                end else begin
                    n_ge  = r_ge + 1'b1;
                    n_len = r_len - 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_oc    = '0;
                    n_ocv   = 1'b0;
                    n_olast = 1'b1;
                    n_ost   = r_st;
                    n_olen  = r_len;
                    n_omod  = r_mod;
                end
            end
            S_RD_ADDR: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = AW'(phys);
            end
            S_RD_DATA: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_oc    = i_mem_rdata;
                    n_ocv   = 1'b1;
                    n_olast = rd_last;
                    n_ost   = ST_OK;
                    n_olen  = r_len;
                    n_omod  = r_mod;
                    n_idx   = r_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gs    <= '0;
            r_ge    <= CAP_L;
            r_len   <= '0;
            r_mod   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gs    <= n_gs;
            r_ge    <= n_ge;
            r_len   <= n_len;
            r_mod   <= n_mod;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_pos   <= n_pos;
        r_ch    <= n_ch;
        r_st    <= n_st;
        r_idx   <= n_idx;
        r_oc    <= n_oc;
        r_ocv   <= n_ocv;
        r_olast <= n_olast;
        r_ost   <= n_ost;
        r_olen  <= n_olen;
        r_omod  <= n_omod;
    end

    assign o_out_valid    = r_ov;
    assign o_char_out     = r_oc;
    assign o_char_valid   = r_ocv;
    assign o_last         = r_olast;
    assign o_status       = r_ost;
    assign o_length_now   = P_POS_W'(r_olen);
    assign o_was_modified = r_omod;

endmodule
`default_nettype wire

// ----- design/gap_buffer_line_editor.sv -----
// top level of the gap buffer line editor
// One line of up to CAPACITY bytes lives in a single-port-pair text memory with a
// movable gap. Requests are taken one at a time: an insert or delete is checked,
// moves the gap one byte per step (memory read, then write back through the one
// write port) and then passes a final gap compare, the edit, the result and the
// return to idle; a clear or a rejected request goes from check to the result; a
// read out returns its beats one by one (read address, then registered read data).
// Results sit in an output register, so the next request is taken while the last
// beat still waits for its consumer.
`default_nettype none
module gap_buffer_line_editor
    import gbl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_req_type,
    input  wire logic [P_POS_W-1:0]  i_position,
    input  wire logic [P_CHAR_W-1:0] i_char_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [P_CHAR_W-1:0]      o_char_out,
    output logic                     o_char_valid,
    output logic                     o_last,
    output logic [1:0]               o_status,
    output logic [P_POS_W-1:0]       o_length_now,
    output logic                     o_was_modified
);

    localparam int AW = $clog2(CAPACITY);

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [P_CHAR_W-1:0] mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [P_CHAR_W-1:0] mem_rdata;

    gbl_text_ram #(
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    gbl_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_char_in      (i_char_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_char_out     (o_char_out),
        .o_char_valid   (o_char_valid),
        .o_last         (o_last),
        .o_status       (o_status),
        .o_length_now   (o_length_now),
        .o_was_modified (o_was_modified),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_length_now <= P_POS_W'(CAPACITY)))
        else $error("length beyond capacity");

    a_ctl_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_char_valid) |-> (o_last && o_char_out == '0))
        else $error("non-data beat not final or not zero");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> !o_char_valid)
        else $error("error status on a data beat");

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_char_valid) |-> (o_length_now != '0))
        else $error("data beat from an empty line");

endmodule
`default_nettype wire
